/* hdl/pis_pkg.sv */
// Shared constants, types and command/status bundles of the pulse interval statistics block.
`default_nettype none
package pis_pkg;

  localparam int MAX_PULSES  = 64;
  localparam int LENGTH_BITS = 24;
  localparam int SAMPLE_BITS = 16;

  localparam int CFG_W    = 7;
  localparam int MEAN_W   = 32;
  localparam int MAXO_W   = 24;
  localparam int FRAC_W   = 8;
  localparam int PTR_W    = (MAX_PULSES > 1) ? $clog2(MAX_PULSES) : 1;
  localparam int USED_W   = $clog2(MAX_PULSES + 1);
  localparam int SUM_W    = LENGTH_BITS + $clog2(MAX_PULSES + 1);
  localparam int NUM_W    = SUM_W + FRAC_W + 1;
  localparam int CNT_LIM  = (MAX_PULSES + 1 > NUM_W) ? MAX_PULSES + 1 : NUM_W;
  localparam int CNT_W    = $clog2(CNT_LIM);
  localparam int KEEP_W   = (CFG_W > USED_W) ? CFG_W : USED_W;
  localparam int QX_W     = (NUM_W > MEAN_W) ? NUM_W : MEAN_W + 1;
  localparam int MX_W     = (LENGTH_BITS > MAXO_W) ? LENGTH_BITS : MAXO_W;
  localparam int OUT_W    = 2 * MEAN_W + 2 * MAXO_W;

  typedef struct packed {
    logic [PTR_W-1:0]  oldest;
    logic [USED_W-1:0] used;
  } pis_win_t;

  typedef struct packed {
    logic init_wr;
    logic take;
    logic upd;
    logic bump;
    logic walk;
    logic div_load;
    logic div_step;
    logic load_out;
  } pis_cmd_t;

  typedef struct packed {
    logic walk_last;
    logic div_last;
  } pis_sts_t;

endpackage
`default_nettype wire

/* hdl/pis_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module pis_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 wr_en,
  input  wire logic [AW-1:0]        wr_addr,
  input  wire logic [WIDTH-1:0]     wr_data,
  input  wire logic [AW-1:0]        rd_addr,
  output logic      [WIDTH-1:0]     rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data <= mem_r[rd_addr];
  end
endmodule
`default_nettype wire

/* hdl/pis_ctrl.sv */
// Sequencing state machine of the pulse interval statistics block.
`default_nettype none
module pis_ctrl
  import pis_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  wire logic     out_tready,
  input  wire pis_sts_t sts,
  output pis_cmd_t      cmd
);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_UPD, S_BUMP, S_WALK, S_DRAIN, S_DIVLD, S_DIV, S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   in_rdy_r, in_rdy_nxt;
  logic   out_vld_r, out_vld_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_INIT: begin
        cmd.init_wr = 1'b1;
        state_nxt   = S_IDLE;
      end
      S_IDLE: begin
        cmd.take = in_tvalid && in_rdy_r;
        if (cmd.take) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = S_BUMP;
      end
      S_BUMP: begin
        cmd.bump  = 1'b1;
        state_nxt = S_WALK;
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (sts.walk_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_DIVLD;
      end
      S_DIVLD: begin
        cmd.div_load = 1'b1;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.load_out = !out_vld_r || out_tready;
        if (cmd.load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
    in_rdy_nxt = (state_nxt == S_IDLE);
    if (cmd.load_out) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_INIT;
      in_rdy_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      in_rdy_r  <= in_rdy_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  assign in_tready  = in_rdy_r;
  assign out_tvalid = out_vld_r;

  a_take_starts_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_rdy_r) |=> (state_r == S_UPD))
    else $error("accepted beat did not start an update");

  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_rdy_r)
    else $error("ready raised while an item is in progress");

  a_walk_then_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK && sts.walk_last) |=> (state_r == S_DRAIN))
    else $error("walk did not end in the drain cycle");

  a_div_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> ($past(state_r) == S_DIVLD || $past(state_r) == S_DIV))
    else $error("divider entered without a load");

endmodule
`default_nettype wire

/* hdl/pis_dp.sv */
// Datapath: pulse length rings, window walk, serial dividers and result register.
`default_nettype none
module pis_dp
  import pis_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire pis_cmd_t               cmd,
  output pis_sts_t                    sts,
  input  wire logic [SAMPLE_BITS-1:0] in_tdata,
  input  wire logic                   cfg_wr_en,
  input  wire logic [CFG_W-1:0]       cfg_wr_data,
  output logic      [OUT_W-1:0]       out_tdata
);

  function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] a,
                                                input logic [PTR_W-1:0] b);
    logic [PTR_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (PTR_W+1)'(MAX_PULSES)) begin
      s = s - (PTR_W+1)'(MAX_PULSES);
    end
    return s[PTR_W-1:0];
  endfunction

  function automatic logic [PTR_W-1:0] last_of(input pis_win_t w);
    logic [USED_W-1:0] um1;
    um1 = w.used - 1'b1;
    return ring_add(w.oldest, um1[PTR_W-1:0]);
  endfunction

  function automatic pis_win_t win_open(input pis_win_t w, input logic [USED_W-1:0] keep);
    pis_win_t          r;
    logic [USED_W-1:0] u2;
    logic [USED_W-1:0] d;
    r = w;
    if (w.used >= USED_W'(MAX_PULSES)) begin
      r.oldest = ring_add(w.oldest, PTR_W'(1));
      r.used   = w.used - 1'b1;
    end
    u2 = r.used + 1'b1;
    d  = u2 - keep;
    if (u2 > keep) begin
      r.oldest = ring_add(r.oldest, d[PTR_W-1:0]);
      r.used   = keep;
    end else begin
      r.used = u2;
    end
    return r;
  endfunction

  function automatic logic [MEAN_W-1:0] sat_mean(input logic [NUM_W-1:0] q);
    logic [QX_W-1:0] w;
    w = QX_W'(q);
    if (w > QX_W'({MEAN_W{1'b1}})) begin
      return {MEAN_W{1'b1}};
    end
    return w[MEAN_W-1:0];
  endfunction

  function automatic logic [MAXO_W-1:0] sat_max(input logic [LENGTH_BITS-1:0] v);
    logic [MX_W-1:0] w;
    w = MX_W'(v);
    if (w > MX_W'({MAXO_W{1'b1}})) begin
      return {MAXO_W{1'b1}};
    end
    return w[MAXO_W-1:0];
  endfunction

  function automatic logic [LENGTH_BITS-1:0] sat_inc(input logic [LENGTH_BITS-1:0] v);
    if (v == {LENGTH_BITS{1'b1}}) begin
      return v;
    end
    return v + 1'b1;
  endfunction

  // Configuration and effective window size.
  logic [CFG_W-1:0]  max_flips_r;
  logic [USED_W-1:0] keep;

  always_comb begin
    if (max_flips_r == '0) begin
      keep = USED_W'(1);
    end else if (KEEP_W'(max_flips_r) > KEEP_W'(MAX_PULSES)) begin
      keep = USED_W'(MAX_PULSES);
    end else begin
      keep = USED_W'(max_flips_r);
    end
  end

  // Window pointers and sample class.
  pis_win_t         pos_win_r, neg_win_r;
  pis_win_t         pos_new, neg_new;
  logic             prev_pos_r, pos_flag_r, neg_flag_r;
  logic             open_pos, open_neg;
  logic             bump_pos_r, opened_r;
  logic [PTR_W-1:0] last_idx_r;

  assign open_pos = pos_flag_r && !prev_pos_r;
  assign open_neg = neg_flag_r && prev_pos_r;
  assign pos_new  = open_pos ? win_open(pos_win_r, keep) : pos_win_r;
  assign neg_new  = open_neg ? win_open(neg_win_r, keep) : neg_win_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_flips_r <= CFG_W'(1);
      prev_pos_r  <= 1'b0;
      pos_win_r   <= '{oldest: '0, used: USED_W'(1)};
      neg_win_r   <= '{oldest: '0, used: USED_W'(1)};
    end else begin
      if (cfg_wr_en) begin
        max_flips_r <= cfg_wr_data;
      end
      if (cmd.upd) begin
        prev_pos_r <= pos_flag_r;
        pos_win_r  <= pos_new;
        neg_win_r  <= neg_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      neg_flag_r <= in_tdata[SAMPLE_BITS-1];
      pos_flag_r <= !in_tdata[SAMPLE_BITS-1] && (in_tdata != '0);
    end
    if (cmd.upd) begin
      bump_pos_r <= pos_flag_r;
      opened_r   <= open_pos || open_neg;
      last_idx_r <= pos_flag_r ? last_of(pos_new) : last_of(neg_new);
    end
  end

  // Ring memories.
  logic                   pos_we, neg_we;
  logic [PTR_W-1:0]       wr_addr;
  logic [LENGTH_BITS-1:0] pos_wdata, neg_wdata;
  logic [PTR_W-1:0]       pos_raddr, neg_raddr;
  logic [LENGTH_BITS-1:0] pos_rdata, neg_rdata;
  logic [CNT_W-1:0]       cnt_r;

  assign pos_we    = cmd.init_wr || (cmd.bump && bump_pos_r);
  assign neg_we    = cmd.init_wr || (cmd.bump && !bump_pos_r);
  assign wr_addr   = cmd.init_wr ? '0 : last_idx_r;
  assign pos_wdata = cmd.init_wr ? '0 :
                     opened_r ? LENGTH_BITS'(1) : sat_inc(pos_rdata);
  assign neg_wdata = cmd.init_wr ? '0 :
                     opened_r ? LENGTH_BITS'(1) : sat_inc(neg_rdata);
  assign pos_raddr = cmd.walk ? ring_add(pos_win_r.oldest, cnt_r[PTR_W-1:0])
                              : last_of(pos_win_r);
  assign neg_raddr = cmd.walk ? ring_add(neg_win_r.oldest, cnt_r[PTR_W-1:0])
                              : last_of(neg_win_r);

  pis_ram #(.WIDTH(LENGTH_BITS), .DEPTH(MAX_PULSES)) u_pos_ram (
    .clk     (clk),
    .wr_en   (pos_we),
    .wr_addr (wr_addr),
    .wr_data (pos_wdata),
    .rd_addr (pos_raddr),
    .rd_data (pos_rdata)
  );

  pis_ram #(.WIDTH(LENGTH_BITS), .DEPTH(MAX_PULSES)) u_neg_ram (
    .clk     (clk),
    .wr_en   (neg_we),
    .wr_addr (wr_addr),
    .wr_data (neg_wdata),
    .rd_addr (neg_raddr),
    .rd_data (neg_rdata)
  );

  // Walk accumulation: read data lands in the cycle after its address.
  logic                   rd_vld_r, pos_in_r, neg_in_r;
  logic [SUM_W-1:0]       psum_r, nsum_r;
  logic [LENGTH_BITS-1:0] pmax_r, nmax_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      rd_vld_r <= cmd.walk;
      if (cmd.bump || cmd.div_load) begin
        cnt_r <= '0;
      end else if (cmd.walk || cmd.div_step) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos_in_r <= cnt_r < CNT_W'(pos_win_r.used);
    neg_in_r <= cnt_r < CNT_W'(neg_win_r.used);
    if (cmd.bump) begin
      psum_r <= '0;
      nsum_r <= '0;
      pmax_r <= '0;
      nmax_r <= '0;
    end else if (rd_vld_r) begin
      if (pos_in_r) begin
        psum_r <= psum_r + SUM_W'(pos_rdata);
        if (pos_rdata > pmax_r) begin
          pmax_r <= pos_rdata;
        end
      end
      if (neg_in_r) begin
        nsum_r <= nsum_r + SUM_W'(neg_rdata);
        if (neg_rdata > nmax_r) begin
          nmax_r <= neg_rdata;
        end
      end
    end
  end

  // Two restoring dividers: round((sum * 256) / keep), half up, one bit a cycle.
  logic [NUM_W-1:0]  pq_r, nq_r;
  logic [USED_W-1:0] prem_r, nrem_r;
  logic [USED_W:0]   psh, nsh, ptry, ntry;

  assign psh  = {prem_r, pq_r[NUM_W-1]};
  assign nsh  = {nrem_r, nq_r[NUM_W-1]};
  assign ptry = psh - {1'b0, keep};
  assign ntry = nsh - {1'b0, keep};

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      pq_r   <= NUM_W'({psum_r, {FRAC_W{1'b0}}}) + NUM_W'(keep >> 1);
      nq_r   <= NUM_W'({nsum_r, {FRAC_W{1'b0}}}) + NUM_W'(keep >> 1);
      prem_r <= '0;
      nrem_r <= '0;
    end else if (cmd.div_step) begin
      prem_r <= ptry[USED_W] ? psh[USED_W-1:0] : ptry[USED_W-1:0];
      nrem_r <= ntry[USED_W] ? nsh[USED_W-1:0] : ntry[USED_W-1:0];
      pq_r   <= {pq_r[NUM_W-2:0], !ptry[USED_W]};
      nq_r   <= {nq_r[NUM_W-2:0], !ntry[USED_W]};
    end
  end

  assign sts.walk_last = (cnt_r == CNT_W'(MAX_PULSES - 1));
  assign sts.div_last  = (cnt_r == CNT_W'(NUM_W - 1));

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_tdata <= {sat_max(nmax_r), sat_max(pmax_r), sat_mean(nq_r), sat_mean(pq_r)};
    end
  end

  a_pos_used_range: assert property (@(posedge clk) disable iff (!rst_n)
    (pos_win_r.used != '0) && (pos_win_r.used <= USED_W'(MAX_PULSES)))
    else $error("positive window fill out of range");

  a_neg_used_range: assert property (@(posedge clk) disable iff (!rst_n)
    (neg_win_r.used != '0) && (neg_win_r.used <= USED_W'(MAX_PULSES)))
    else $error("negative window fill out of range");

  a_sums_settled: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_load |-> !rd_vld_r)
    else $error("divider loaded while walk data still in flight");

endmodule
`default_nettype wire

/* hdl/pulse_interval_stats.sv */
// Top level of the pulse interval statistics block: controller, datapath and ports.
// A result beat is offered once its accepted input beat has gone through all phases
// (update, read-modify-write, a 64-entry walk of both rings, drain, 40 divider steps).
// Beats are taken one at a time, each once the previous result is loaded; the ring walk
// through the one read port of each ring memory and the bit-serial dividers set the pace.
// Reset: synchronous, active low; after release the init state writes entry zero of both
// rings, then the block accepts input. max_flips resets to 1.
`default_nettype none
module pulse_interval_stats
  import pis_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // Input channel; tdata holds sample (bits 15:0).
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [SAMPLE_BITS-1:0] in_tdata,
  // Result channel; tdata holds mean_pos (31:0), mean_neg (63:32),
  // max_pos (87:64) and max_neg (111:88).
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic      [OUT_W-1:0]       out_tdata,
  // Configuration: max_flips, written whenever the write enable is high.
  input  wire logic                   cfg_wr_en,
  input  wire logic [CFG_W-1:0]       cfg_wr_data
);

  // The controller steps each accepted beat through its phases and owns the
  // handshake flags; the datapath holds the rings, the sums and the result.
  pis_cmd_t cmd;
  pis_sts_t sts;

  pis_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // The result register lets a new beat be taken while the previous result
  // still waits on the output side.
  pis_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_tdata    (in_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_tdata   (out_tdata)
  );

endmodule
`default_nettype wire
